FILE: rtl/skf_pkg.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter package
// Widths, register indexes, modes, reset values and the control type shared
// by the filter and its bit-serial arithmetic units.
// ----------------------------------------------------------------------------
package skf_pkg;

    // Q16.16 data
    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    // gain in [0, 1.0]: one integer bit above the fraction
    localparam int GAIN_W   = FRAC_W + 1;
    // innovation magnitude and P+R both need one extra bit
    localparam int MAG_W    = DATA_W + 1;
    // product shifted right by the fraction width
    localparam int SCALED_W = MAG_W + 1;
    // one serial step per gain bit, for both division and multiplication
    localparam int STEPS    = GAIN_W;
    localparam int STEP_W   = $clog2(STEPS);
    localparam int COUNT_W  = 32;
    localparam int CFG_IDX_W = 2;
    localparam int MODE_W   = 2;

    localparam logic [GAIN_W-1:0] ONE_Q = GAIN_W'(1) << FRAC_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INIT_EST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_COV = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 2'd3;

    // request modes
    localparam logic [MODE_W-1:0] MODE_PRED_UPD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PRED     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UPD      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE     = 2'd3;

    // reset values
    localparam logic [DATA_W-1:0] RESET_ESTIMATE   = 32'd0;
    localparam logic [DATA_W-1:0] RESET_COVARIANCE = 32'd65536;
    localparam logic [DATA_W-1:0] RESET_PROC_NOISE = 32'd655;
    localparam logic [DATA_W-1:0] RESET_MEAS_NOISE = 32'd65536;

    // load / step strobes for a serial unit
    typedef struct packed {
        logic load;
        logic step;
    } t_ser_ctrl;

endpackage

FILE: rtl/scalar_kalman_filter.sv
// One request at a time: a new request is taken only after the result of the
// last one is loaded into the output register. An update runs the serial
// divider (17 steps) then the serial multipliers (17 steps), one gain bit per
// cycle each.
// Reset (synchronous, active low) restores registers to their defaults and
// the state to estimate 0, covariance 1.0 and a zero update count.
// ----------------------------------------------------------------------------
// Scalar Kalman filter
// Constant-state 1-D filter in Q16.16: predict grows P by Q (saturating),
// update applies gain P/(P+R) to estimate and covariance.
// ----------------------------------------------------------------------------
module scalar_kalman_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [skf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]        i_cfg_data,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [skf_pkg::MODE_W-1:0]        i_mode,
    input  logic signed [skf_pkg::DATA_W-1:0] i_measurement,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [skf_pkg::DATA_W-1:0] o_estimate,
    output logic [skf_pkg::DATA_W-1:0]        o_covariance,
    output logic [skf_pkg::COUNT_W-1:0]       o_update_count
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PRED  = 3'd1;
    localparam logic [2:0] ST_SETUP = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_GAIN  = 3'd4;
    localparam logic [2:0] ST_MUL   = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    localparam logic [skf_pkg::STEP_W-1:0] LAST_STEP = skf_pkg::STEP_W'(skf_pkg::STEPS - 1);

    logic [2:0]                        r_state, n_state;
    logic [skf_pkg::STEP_W-1:0]        r_cnt;
    logic [skf_pkg::MODE_W-1:0]        r_mode;
    logic [skf_pkg::DATA_W-1:0]        r_meas;
    logic [skf_pkg::DATA_W-1:0]        r_est;
    logic [skf_pkg::DATA_W-1:0]        r_cov;
    logic [skf_pkg::COUNT_W-1:0]       r_updates;
    logic [skf_pkg::DATA_W-1:0]        r_q;
    logic [skf_pkg::DATA_W-1:0]        r_r;
    logic [skf_pkg::MAG_W-1:0]         r_innov;
    logic                              r_s_zero;
    logic                              r_out_valid;
    logic [skf_pkg::DATA_W-1:0]        r_out_est;
    logic [skf_pkg::DATA_W-1:0]        r_out_cov;
    logic [skf_pkg::COUNT_W-1:0]       r_out_cnt;

    skf_pkg::t_ser_ctrl                div_ctrl;
    skf_pkg::t_ser_ctrl                mul_ctrl;
    logic [skf_pkg::MAG_W-1:0]         pred_sum;
    logic [skf_pkg::MAG_W-1:0]         s_sum;
    logic [skf_pkg::MAG_W-1:0]         innov;
    logic [skf_pkg::MAG_W-1:0]         mag;
    logic [skf_pkg::GAIN_W-1:0]        quot;
    logic [skf_pkg::GAIN_W-1:0]        gain;
    logic [skf_pkg::GAIN_W-1:0]        one_minus_gain;
    logic [skf_pkg::SCALED_W-1:0]      delta_scaled;
    logic [skf_pkg::SCALED_W-1:0]      cov_scaled;
    logic [skf_pkg::MAG_W-1:0]         est_ext;
    logic [skf_pkg::MAG_W-1:0]         est_new;
    logic                              accept;
    logic                              out_load;
    logic                              do_update;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_load    = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    assign do_update   = (r_mode == skf_pkg::MODE_PRED_UPD) || (r_mode == skf_pkg::MODE_UPD);

    // datapath arithmetic, all combinational
    always_comb begin
        pred_sum       = {1'b0, r_cov} + {1'b0, r_q};
        s_sum          = {1'b0, r_cov} + {1'b0, r_r};
        innov          = {r_meas[skf_pkg::DATA_W-1], r_meas} -
                         {r_est[skf_pkg::DATA_W-1], r_est};
        mag            = r_innov[skf_pkg::MAG_W-1] ? (~r_innov + 1'b1) : r_innov;
        gain           = r_s_zero ? '0 : quot;
        one_minus_gain = skf_pkg::ONE_Q - gain;
        est_ext        = {r_est[skf_pkg::DATA_W-1], r_est};
        // new estimate lies between x and z, so the low bits hold it
        est_new        = r_innov[skf_pkg::MAG_W-1]
                       ? est_ext - delta_scaled[skf_pkg::MAG_W-1:0]
                       : est_ext + delta_scaled[skf_pkg::MAG_W-1:0];
    end

    // serial unit strobes
    always_comb begin
        div_ctrl.load = (r_state == ST_SETUP);
        div_ctrl.step = (r_state == ST_DIV);
        mul_ctrl.load = (r_state == ST_GAIN);
        mul_ctrl.step = (r_state == ST_MUL);
    end

    skf_serdiv u_div (
        .i_clk  (i_clk),
        .i_ctrl (div_ctrl),
        .i_num  (r_cov),
        .i_den  (s_sum),
        .o_quot (quot)
    );

    // gain times innovation magnitude
    skf_sermul u_mul_est (
        .i_clk    (i_clk),
        .i_ctrl   (mul_ctrl),
        .i_mcand  (mag),
        .i_mplier (gain),
        .o_scaled (delta_scaled)
    );

    // covariance times one minus gain
    skf_sermul u_mul_cov (
        .i_clk    (i_clk),
        .i_ctrl   (mul_ctrl),
        .i_mcand  ({1'b0, r_cov}),
        .i_mplier (one_minus_gain),
        .o_scaled (cov_scaled)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        skf_pkg::MODE_PRED_UPD: n_state = ST_PRED;
                        skf_pkg::MODE_PRED:     n_state = ST_PRED;
                        skf_pkg::MODE_UPD:      n_state = ST_SETUP;
                        default:                n_state = ST_DONE;
                    endcase
                end
            end
            ST_PRED:  n_state = do_update ? ST_SETUP : ST_DONE;
            ST_SETUP: n_state = ST_DIV;
            ST_DIV:   n_state = (r_cnt == LAST_STEP) ? ST_GAIN : ST_DIV;
            ST_GAIN:  n_state = ST_MUL;
            ST_MUL:   n_state = (r_cnt == LAST_STEP) ? ST_FIN : ST_MUL;
            ST_FIN:   n_state = ST_DONE;
            ST_DONE:  n_state = out_load ? ST_IDLE : ST_DONE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DIV || r_state == ST_MUL) begin
                r_cnt <= (r_cnt == LAST_STEP) ? '0 : r_cnt + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // filter state and noise registers; writes to the initial-value indexes
    // are ignored and reset loads the default values into the state,
    // so the state always restarts from the default values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est     <= skf_pkg::RESET_ESTIMATE;
            r_cov     <= skf_pkg::RESET_COVARIANCE;
            r_updates <= '0;
            r_q       <= skf_pkg::RESET_PROC_NOISE;
            r_r       <= skf_pkg::RESET_MEAS_NOISE;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    skf_pkg::REG_PROC_NOISE: r_q <= i_cfg_data;
                    skf_pkg::REG_MEAS_NOISE: r_r <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == ST_PRED) begin
                // saturate at full scale
                r_cov <= pred_sum[skf_pkg::DATA_W] ? '1 : pred_sum[skf_pkg::DATA_W-1:0];
            end
            if (r_state == ST_FIN) begin
                r_est     <= est_new[skf_pkg::DATA_W-1:0];
                r_cov     <= cov_scaled[skf_pkg::DATA_W-1:0];
                r_updates <= r_updates + 1'b1;
            end
        end
    end

    // request capture and per-update working values
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_mode;
            r_meas <= i_measurement;
        end
        if (r_state == ST_SETUP) begin
            r_innov  <= innov;
            r_s_zero <= (s_sum == '0);
        end
        if (out_load) begin
            r_out_est <= r_est;
            r_out_cov <= r_cov;
            r_out_cnt <= r_updates;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_estimate     = r_out_est;
    assign o_covariance   = r_out_cov;
    assign o_update_count = r_out_cnt;

endmodule

FILE: rtl/skf_serdiv.sv
// ----------------------------------------------------------------------------
// Serial gain divider
// Restoring division producing P * 2^FRAC / S, one quotient bit per step.
// The first step compares without shifting, giving the integer bit.
// ----------------------------------------------------------------------------
module skf_serdiv (
    input  logic                          i_clk,
    input  skf_pkg::t_ser_ctrl            i_ctrl,
    input  logic [skf_pkg::DATA_W-1:0]    i_num,
    input  logic [skf_pkg::MAG_W-1:0]     i_den,
    output logic [skf_pkg::GAIN_W-1:0]    o_quot
);

    logic [skf_pkg::MAG_W-1:0]  r_rem;
    logic [skf_pkg::MAG_W-1:0]  r_den;
    logic [skf_pkg::GAIN_W-1:0] r_quot;
    logic                       r_first;

    logic [skf_pkg::MAG_W:0]    trial;
    logic [skf_pkg::MAG_W:0]    diff;
    logic                       fits;

    // trial remainder and compare
    always_comb begin
        trial = r_first ? {1'b0, r_rem} : {r_rem, 1'b0};
        diff  = trial - {1'b0, r_den};
        fits  = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_rem   <= {1'b0, i_num};
            r_den   <= i_den;
            r_quot  <= '0;
            r_first <= 1'b1;
        end else if (i_ctrl.step) begin
            // remainder stays below the divisor, so it fits MAG_W bits
            r_rem   <= fits ? diff[skf_pkg::MAG_W-1:0] : trial[skf_pkg::MAG_W-1:0];
            r_quot  <= {r_quot[skf_pkg::GAIN_W-2:0], fits};
            r_first <= 1'b0;
        end
    end

    assign o_quot = r_quot;

endmodule

FILE: rtl/skf_sermul.sv
// ----------------------------------------------------------------------------
// Serial Q multiplier
// Shift-add multiply, one multiplier bit per step, LSB first. The result is
// the product shifted right by the fraction width, truncated.
// ----------------------------------------------------------------------------
module skf_sermul (
    input  logic                            i_clk,
    input  skf_pkg::t_ser_ctrl              i_ctrl,
    input  logic [skf_pkg::MAG_W-1:0]       i_mcand,
    input  logic [skf_pkg::GAIN_W-1:0]      i_mplier,
    output logic [skf_pkg::SCALED_W-1:0]    o_scaled
);

    logic [skf_pkg::MAG_W-1:0]  r_mcand;
    logic [skf_pkg::GAIN_W-1:0] r_mplier;
    logic [skf_pkg::MAG_W-1:0]  r_hi;
    logic [skf_pkg::GAIN_W-1:0] r_lo;

    logic [skf_pkg::MAG_W:0]    sum;

    // partial sum for the current multiplier bit
    always_comb begin
        sum = {1'b0, r_hi} + (r_mplier[0] ? {1'b0, r_mcand} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_mcand  <= i_mcand;
            r_mplier <= i_mplier;
            r_hi     <= '0;
            r_lo     <= '0;
        end else if (i_ctrl.step) begin
            // shift the product right, low bits spill into r_lo
            r_hi     <= sum[skf_pkg::MAG_W:1];
            r_lo     <= {sum[0], r_lo[skf_pkg::GAIN_W-1:1]};
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_scaled = {r_hi, r_lo[skf_pkg::GAIN_W-1:skf_pkg::FRAC_W]};

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scalar Kalman filter testbench
// Drives predict/update requests and register writes through their handshakes
// and checks each result against a fixed-point filter model kept alongside or
// a hand-typed value. A directed table covers the extremes and corner cases;
// random segments follow with changing noise settings and idling patterns.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SEGMENTS       = 8;
    localparam int SEG_REQUESTS   = 138;
    localparam int DRAIN_CYCLES   = 60;
    localparam int SHOW_LIMIT     = 10;

    typedef struct packed {
        logic [skf_pkg::DATA_W-1:0]  est;
        logic [skf_pkg::DATA_W-1:0]  cov;
        logic [skf_pkg::COUNT_W-1:0] count;
    } t_filt_result;

    // one directed row: a register write or a request, optionally with a
    // hand-typed result
    typedef struct packed {
        logic                        is_write;
        logic [1:0]                  sel;
        logic [skf_pkg::DATA_W-1:0]  value;
        logic                        typed;
        logic [skf_pkg::DATA_W-1:0]  w_est;
        logic [skf_pkg::DATA_W-1:0]  w_cov;
        logic [skf_pkg::COUNT_W-1:0] w_count;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 26;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // state straight after reset
        '{1'b0, skf_pkg::MODE_NONE, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'd65536, 32'd0},
        '{1'b0, skf_pkg::MODE_PRED, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, 32'd66191, 32'd0},
        '{1'b0, skf_pkg::MODE_PRED_UPD, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, 32'h0},
        '{1'b0, skf_pkg::MODE_UPD,      32'h8000_0000, 1'b0, 32'h0, 32'h0, 32'h0},
        '{1'b0, skf_pkg::MODE_PRED_UPD, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 32'h0},
        '{1'b0, skf_pkg::MODE_UPD,      32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 32'h0},
        '{1'b0, skf_pkg::MODE_PRED_UPD, 32'h0000_0001, 1'b0, 32'h0, 32'h0, 32'h0},
        '{1'b0, skf_pkg::MODE_NONE,     32'hAAAA_AAAA, 1'b0, 32'h0, 32'h0, 32'h0},
        // zero measurement noise: gain of one, covariance collapses
        '{1'b1, skf_pkg::REG_MEAS_NOISE, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 32'h0},
        '{1'b0, skf_pkg::MODE_UPD, 32'h1234_5678, 1'b1, 32'h1234_5678, 32'd0, 32'd6},
        // P and R both zero: gain forced to zero
        '{1'b0, skf_pkg::MODE_UPD, 32'h5555_5555, 1'b1, 32'h1234_5678, 32'd0, 32'd7},
        '{1'b0, skf_pkg::MODE_PRED, 32'h0000_0000, 1'b1, 32'h1234_5678, 32'd655, 32'd7},
        '{1'b0, skf_pkg::MODE_PRED_UPD, 32'h8000_0000, 1'b1, 32'h8000_0000, 32'd0, 32'd8},
        // covariance saturation on predict
        '{1'b1, skf_pkg::REG_PROC_NOISE, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 32'h0},
        '{1'b0, skf_pkg::MODE_PRED, 32'h0000_0000, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 32'd8},
        '{1'b0, skf_pkg::MODE_PRED, 32'h0000_0000, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 32'd8},
        '{1'b0, skf_pkg::MODE_PRED_UPD, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'd0, 32'd9},
        // largest P + R
        '{1'b1, skf_pkg::REG_MEAS_NOISE, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 32'h0},
        '{1'b0, skf_pkg::MODE_PRED, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd9},
        '{1'b0, skf_pkg::MODE_UPD,      32'h8000_0000, 1'b0, 32'h0, 32'h0, 32'h0},
        '{1'b0, skf_pkg::MODE_PRED_UPD, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 32'h0},
        // initial-value writes are ignored by the filter
        '{1'b1, skf_pkg::REG_INIT_EST,   32'h8000_0000, 1'b0, 32'h0, 32'h0, 32'h0},
        '{1'b1, skf_pkg::REG_INIT_COV,   32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 32'h0},
        '{1'b0, skf_pkg::MODE_NONE,      32'h0000_0000, 1'b0, 32'h0, 32'h0, 32'h0},
        '{1'b1, skf_pkg::REG_PROC_NOISE, skf_pkg::RESET_PROC_NOISE, 1'b0, 32'h0, 32'h0, 32'h0},
        '{1'b1, skf_pkg::REG_MEAS_NOISE, skf_pkg::RESET_MEAS_NOISE, 1'b0, 32'h0, 32'h0, 32'h0}
    };

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [skf_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [skf_pkg::DATA_W-1:0]        i_cfg_data;
    logic                              i_in_valid;
    logic                              o_in_ready;
    logic [skf_pkg::MODE_W-1:0]        i_mode;
    logic signed [skf_pkg::DATA_W-1:0] i_measurement;
    logic                              o_out_valid;
    logic                              i_out_ready;
    logic signed [skf_pkg::DATA_W-1:0] o_estimate;
    logic [skf_pkg::DATA_W-1:0]        o_covariance;
    logic [skf_pkg::COUNT_W-1:0]       o_update_count;

    // filter model: noise registers and state
    logic [skf_pkg::DATA_W-1:0]        proc_noise;
    logic [skf_pkg::DATA_W-1:0]        meas_noise;
    logic [skf_pkg::DATA_W-1:0]        filt_est;
    logic [skf_pkg::DATA_W-1:0]        filt_cov;
    logic [skf_pkg::COUNT_W-1:0]       filt_count;

    t_filt_result                      pending_results[$];
    int                                mismatches;
    int                                idle_cycles;
    int                                req_gap_pct;
    int                                out_stall_pct;

    scalar_kalman_filter uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_measurement  (i_measurement),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_estimate     (o_estimate),
        .o_covariance   (o_covariance),
        .o_update_count (o_update_count)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // advance the model by one request and return what it reports
    function automatic t_filt_result filter_step(input logic [skf_pkg::MODE_W-1:0] mode,
                                                 input logic [skf_pkg::DATA_W-1:0] z);
        logic [63:0]        sum;
        logic [63:0]        gain;
        logic [63:0]        mag;
        logic [63:0]        delta;
        logic [63:0]        scaled;
        logic signed [63:0] innov;
        t_filt_result       res;
        // predict: P grows by Q, clamped at full scale
        if (mode == skf_pkg::MODE_PRED_UPD || mode == skf_pkg::MODE_PRED) begin
            sum = 64'(filt_cov) + 64'(proc_noise);
            filt_cov = (sum > 64'hFFFF_FFFF) ? '1 : sum[skf_pkg::DATA_W-1:0];
        end
        // update: gain P/(P+R), zero when the sum is zero
        if (mode == skf_pkg::MODE_PRED_UPD || mode == skf_pkg::MODE_UPD) begin
            sum   = 64'(filt_cov) + 64'(meas_noise);
            gain  = (sum == 0) ? 64'd0 : (64'(filt_cov) << skf_pkg::FRAC_W) / sum;
            innov = $signed({{32{z[skf_pkg::DATA_W-1]}}, z})
                  - $signed({{32{filt_est[skf_pkg::DATA_W-1]}}, filt_est});
            mag   = (innov < 0) ? 64'(-innov) : 64'(innov);
            delta = (mag * gain) >> skf_pkg::FRAC_W;
            filt_est = (innov < 0) ? filt_est - delta[skf_pkg::DATA_W-1:0]
                                   : filt_est + delta[skf_pkg::DATA_W-1:0];
            scaled   = (64'(filt_cov) * ((64'd1 << skf_pkg::FRAC_W) - gain))
                     >> skf_pkg::FRAC_W;
            filt_cov = scaled[skf_pkg::DATA_W-1:0];
            filt_count = filt_count + 1'b1;
        end
        res.est   = filt_est;
        res.cov   = filt_cov;
        res.count = filt_count;
        return res;
    endfunction

    // noise setting: extremes, small values or anything
    function automatic logic [skf_pkg::DATA_W-1:0] pick_noise();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return skf_pkg::DATA_W'($urandom_range(0, 4096));
            3:       return skf_pkg::DATA_W'($urandom_range(0, 1 << 20));
            default: return $urandom;
        endcase
    endfunction

    // register write; only issued once the filter has drained
    task automatic write_reg(input logic [skf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [skf_pkg::DATA_W-1:0] data);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        // initial-value writes are ignored, as in the filter
        case (idx)
            skf_pkg::REG_PROC_NOISE: proc_noise = data;
            skf_pkg::REG_MEAS_NOISE: meas_noise = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one request; entered and left at a falling edge
    task automatic push_request(input logic [skf_pkg::MODE_W-1:0] mode,
                                input logic [skf_pkg::DATA_W-1:0] z,
                                input logic typed, input t_filt_result want);
        t_filt_result model_res;
        while ($urandom_range(1, 100) <= req_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_measurement <= z;
        do @(posedge i_clk); while (!o_in_ready);
        model_res = filter_step(mode, z);
        pending_results.push_back(typed ? want : model_res);
        @(negedge i_clk);
    endtask

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(1, 100) <= out_stall_pct) ? 1'b0 : 1'b1;
    end

    // result checker
    always @(posedge i_clk) begin
        t_filt_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("unexpected result: est %h cov %h count %h",
                             o_estimate, o_covariance, o_update_count);
            end else begin
                want = pending_results.pop_front();
                if (o_estimate !== want.est || o_covariance !== want.cov ||
                    o_update_count !== want.count) begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display("mismatch: est %h/%h cov %h/%h count %h/%h (exp/got)",
                                 want.est, o_estimate, want.cov, o_covariance,
                                 want.count, o_update_count);
                end
            end
        end
    end

    // watchdog on cycles with no accepted request, result or write
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_filt_result                no_want;
        t_filt_result                row_want;
        logic [skf_pkg::MODE_W-1:0]  mode;
        logic [skf_pkg::DATA_W-1:0]  z;
        int                          pick;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_mode        = skf_pkg::MODE_NONE;
        i_measurement = '0;
        i_out_ready   = 1'b0;
        mismatches    = 0;
        idle_cycles   = 0;
        req_gap_pct   = 0;
        out_stall_pct = 0;
        no_want       = '0;
        row_want      = '0;
        proc_noise    = skf_pkg::RESET_PROC_NOISE;
        meas_noise    = skf_pkg::RESET_MEAS_NOISE;
        filt_est      = skf_pkg::RESET_ESTIMATE;
        filt_cov      = skf_pkg::RESET_COVARIANCE;
        filt_count    = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        for (int n = 0; n < DIRECTED_ROWS; n++) begin
            if (DIRECTED[n].is_write) begin
                write_reg(DIRECTED[n].sel, DIRECTED[n].value);
            end else begin
                row_want.est   = DIRECTED[n].w_est;
                row_want.cov   = DIRECTED[n].w_cov;
                row_want.count = DIRECTED[n].w_count;
                push_request(DIRECTED[n].sel, DIRECTED[n].value, DIRECTED[n].typed,
                             row_want);
            end
        end

        // random segments, each with fresh noise and its own idling pattern
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            write_reg(skf_pkg::REG_INIT_EST, $urandom);
            write_reg(skf_pkg::REG_INIT_COV, $urandom);
            write_reg(skf_pkg::REG_PROC_NOISE, pick_noise());
            write_reg(skf_pkg::REG_MEAS_NOISE, pick_noise());
            case (seg % 4)
                0: begin req_gap_pct = 0;  out_stall_pct = 0;  end
                1: begin req_gap_pct = 51; out_stall_pct = 0;  end
                2: begin req_gap_pct = 0;  out_stall_pct = 51; end
                default: begin req_gap_pct = 9; out_stall_pct = 9; end
            endcase
            for (int n = 0; n < SEG_REQUESTS; n++) begin
                pick = $urandom_range(0, 99);
                mode = (pick < 60) ? skf_pkg::MODE_PRED_UPD :
                       (pick < 75) ? skf_pkg::MODE_PRED :
                       (pick < 95) ? skf_pkg::MODE_UPD : skf_pkg::MODE_NONE;
                case ($urandom_range(0, 9))
                    0: z = 32'h7FFF_FFFF;
                    1: z = 32'h8000_0000;
                    2, 3, 4, 5:
                        z = filt_est + skf_pkg::DATA_W'($urandom_range(0, 1 << 20))
                          - skf_pkg::DATA_W'(1 << 19);
                    default: z = $urandom;
                endcase
                push_request(mode, z, 1'b0, no_want);
            end
        end
        i_in_valid <= 1'b0;

        // drain, then leave room for anything stray
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
